// File: hw/rtl/path_oram_access_controller_defines.svh
// assertion macros used by poram_ctrl
`ifndef PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH
`define PATH_ORAM_ACCESS_CONTROLLER_DEFINES_SVH

// condition must hold at every edge out of reset
`define PORAM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("poram assertion failed");

// antecedent in this cycle implies consequent in the next one
`define PORAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("poram assertion failed");

`endif

// File: hw/rtl/poram_pkg.sv
`timescale 1ns / 1ps
package poram_pkg;

  localparam int TREE_LEVELS  = 10;
  localparam int LEAF_W       = 10;
  localparam int ID_W         = 10;
  localparam int DATA_W       = 64;
  localparam int BUCKET_SLOTS = 4;
  localparam int SLOT_W       = 2;
  localparam int NUM_LEVELS   = TREE_LEVELS + 1;
  localparam int LVL_W        = 4;
  localparam int STASH_DEPTH  = 64;
  localparam int STASH_W      = 6;
  localparam int BLOCK_CNT    = 1024;
  localparam int TREE_SLOTS   = ((2 << TREE_LEVELS) - 1) * BUCKET_SLOTS;
  localparam int TREE_AW      = 13;
  localparam int PATH_SLOTS   = NUM_LEVELS * BUCKET_SLOTS;
  localparam int CNT_W        = 13;
  localparam int FILL_W       = 3;

  typedef struct packed {
    logic              cmd;
    logic [ID_W-1:0]   block_id;
    logic [DATA_W-1:0] write_data;
    logic [LEAF_W-1:0] fresh_leaf;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_data;
    logic              stash_overflow;
  } out_t;

  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic [LEAF_W-1:0] leaf;
    logic [DATA_W-1:0] word;
  } tree_ent_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LEAF_W-1:0] leaf;
    logic [DATA_W-1:0] word;
  } stash_ent_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_PMAP, ST_PATH_RD, ST_PATH_WR,
    ST_SRCH_RD, ST_SRCH_CHK, ST_EVICT_RD, ST_EVICT_CHK, ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_PMAP, OP_PATH_RD, OP_PATH_WR,
    OP_SRCH_RD, OP_SRCH_CHK, OP_EVICT_RD, OP_EVICT_CHK
  } dp_op_t;

  typedef struct packed {
    logic clr_last;
    logic path_last;
    logic scan_last;
    logic hit;
  } dp_stat_t;

  // tree slot address of a given slot in the bucket at level lvl on leaf's path
  function automatic logic [TREE_AW-1:0] slot_addr(input logic [LEAF_W-1:0] leaf,
                                                  input logic [LVL_W-1:0] lvl,
                                                  input logic [SLOT_W-1:0] slot);
    logic [TREE_AW-1:0] b;
    logic [LEAF_W-1:0]  sh;
    begin
      sh = leaf >> (LVL_W'(TREE_LEVELS) - lvl);
      b  = (TREE_AW'(1) << lvl) - TREE_AW'(1) + TREE_AW'(sh);
      slot_addr = {b[TREE_AW-SLOT_W-1:0], slot};
    end
  endfunction

endpackage

// File: hw/rtl/poram_dp.sv
`timescale 1ns / 1ps
module poram_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  poram_pkg::dp_op_t op,
  input  poram_pkg::in_t    in_item,
  output poram_pkg::dp_stat_t stat,
  output poram_pkg::out_t   out_item
);
  import poram_pkg::*;

  tree_ent_t  tree_mem [TREE_SLOTS];
  logic [LEAF_W-1:0] pmap_mem [BLOCK_CNT];
  stash_ent_t stash_mem [STASH_DEPTH];

  tree_ent_t  tree_q;
  stash_ent_t stash_q;
  logic [LEAF_W-1:0] pmap_q;

  in_t                req_r;
  logic [LEAF_W-1:0]  leaf_r;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FILL_W-1:0]  fill_r [NUM_LEVELS];
  logic [STASH_DEPTH-1:0] vld_r, vld_nxt;
  logic               found_r, found_nxt, ovf_r, ovf_nxt;
  logic [DATA_W-1:0]  rdata_r, rdata_nxt;

  logic [STASH_W-1:0] idx;
  logic [STASH_W-1:0] free_idx;
  logic               free_any;
  logic [TREE_AW-1:0] path_addr, ev_addr;
  logic [NUM_LEVELS-1:0] ok;
  logic [LVL_W-1:0]   sel;
  logic               sel_any;
  logic               tree_we;
  logic [TREE_AW-1:0] tree_waddr;
  tree_ent_t          tree_wdata;
  logic               stash_we;
  logic [STASH_W-1:0] stash_waddr;
  stash_ent_t         stash_wdata;
  logic [LEAF_W-1:0]  diff;

  assign idx       = cnt_r[STASH_W-1:0];
  assign path_addr = slot_addr(leaf_r, cnt_r[SLOT_W+LVL_W-1:SLOT_W], cnt_r[SLOT_W-1:0]);

  // lowest free stash slot
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = STASH_DEPTH - 1; i >= 0; i--) begin
      if (!vld_r[i]) begin
        free_idx = STASH_W'(i);
        free_any = 1'b1;
      end
    end
  end

  // deepest level on the path that covers the entry and has room
  always_comb begin
    diff    = leaf_r ^ stash_q.leaf;
    sel     = '0;
    sel_any = 1'b0;
    for (int d = 0; d < NUM_LEVELS; d++) begin
      ok[d] = ((diff >> (TREE_LEVELS - d)) == '0);
      if (ok[d] && fill_r[d] < FILL_W'(BUCKET_SLOTS)) begin
        sel     = LVL_W'(d);
        sel_any = 1'b1;
      end
    end
  end

  assign ev_addr = slot_addr(leaf_r, sel, fill_r[sel][SLOT_W-1:0]);

  assign stat.clr_last  = (cnt_r == CNT_W'(TREE_SLOTS - 1));
  assign stat.path_last = (cnt_r == CNT_W'(PATH_SLOTS - 1));
  assign stat.scan_last = (idx == {STASH_W{1'b1}});
  assign stat.hit       = vld_r[idx] && (stash_q.id == req_r.block_id);

  always_comb begin
    cnt_nxt     = cnt_r;
    vld_nxt     = vld_r;
    found_nxt   = found_r;
    rdata_nxt   = rdata_r;
    ovf_nxt     = ovf_r;
    tree_we     = 1'b0;
    tree_waddr  = path_addr;
    tree_wdata  = '0;
    stash_we    = 1'b0;
    stash_waddr = free_idx;
    stash_wdata = '0;
    case (op)
      OP_CLEAR: begin
        tree_we    = 1'b1;
        tree_waddr = cnt_r;
        cnt_nxt    = stat.clr_last ? '0 : cnt_r + 1'b1;
      end
      OP_ACCEPT: begin
        found_nxt = 1'b0;
        rdata_nxt = '0;
      end
      OP_PMAP: cnt_nxt = '0;
      OP_PATH_WR: begin
        if (tree_q.vld) begin
          tree_we = 1'b1;
          if (free_any) begin
            stash_we          = 1'b1;
            stash_wdata       = '{id: tree_q.id, leaf: tree_q.leaf, word: tree_q.word};
            vld_nxt[free_idx] = 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        cnt_nxt = stat.path_last ? '0 : cnt_r + 1'b1;
      end
      OP_SRCH_CHK: begin
        if (stat.hit) begin
          found_nxt   = 1'b1;
          rdata_nxt   = stash_q.word;
          stash_we    = 1'b1;
          stash_waddr = idx;
          stash_wdata = '{id: req_r.block_id, leaf: req_r.fresh_leaf,
                          word: req_r.cmd ? req_r.write_data : stash_q.word};
          cnt_nxt     = '0;
        end else if (stat.scan_last) begin
          if (req_r.cmd) begin
            found_nxt = 1'b1;
            rdata_nxt = req_r.write_data;
            if (free_any) begin
              stash_we          = 1'b1;
              stash_wdata       = '{id: req_r.block_id, leaf: req_r.fresh_leaf,
                                    word: req_r.write_data};
              vld_nxt[free_idx] = 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      OP_EVICT_CHK: begin
        if (vld_r[idx] && sel_any) begin
          tree_we      = 1'b1;
          tree_waddr   = ev_addr;
          tree_wdata   = '{vld: 1'b1, id: stash_q.id, leaf: stash_q.leaf,
                           word: stash_q.word};
          vld_nxt[idx] = 1'b0;
        end
        cnt_nxt = stat.scan_last ? '0 : cnt_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      vld_r   <= '0;
      ovf_r   <= 1'b0;
      found_r <= 1'b0;
      rdata_r <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      vld_r   <= vld_nxt;
      ovf_r   <= ovf_nxt;
      found_r <= found_nxt;
      rdata_r <= rdata_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_ACCEPT) begin
      req_r <= in_item;
    end
    if (op == OP_PMAP) begin
      leaf_r <= pmap_q;
    end
    for (int d = 0; d < NUM_LEVELS; d++) begin
      if (op == OP_PMAP) begin
        fill_r[d] <= '0;
      end else if (op == OP_EVICT_CHK && vld_r[idx] && sel_any && sel == LVL_W'(d)) begin
        fill_r[d] <= fill_r[d] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tree_we) begin
      tree_mem[tree_waddr] <= tree_wdata;
    end
    tree_q <= tree_mem[path_addr];
  end

  always_ff @(posedge clk) begin
    if (op == OP_CLEAR && cnt_r[CNT_W-1:ID_W] == '0) begin
      pmap_mem[cnt_r[ID_W-1:0]] <= '0;
    end else if (op == OP_PMAP) begin
      pmap_mem[req_r.block_id] <= req_r.fresh_leaf;
    end
    pmap_q <= pmap_mem[in_item.block_id];
  end

  always_ff @(posedge clk) begin
    if (stash_we) begin
      stash_mem[stash_waddr] <= stash_wdata;
    end
    stash_q <= stash_mem[idx];
  end

  assign out_item.found          = found_r;
  assign out_item.read_data      = rdata_r;
  assign out_item.stash_overflow = ovf_r;

endmodule

// File: hw/rtl/poram_ctrl.sv
`timescale 1ns / 1ps
`include "path_oram_access_controller_defines.svh"
module poram_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  input  poram_pkg::dp_stat_t stat,
  output poram_pkg::dp_op_t   op
);
  import poram_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:     if (stat.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:      if (start) state_nxt = ST_PMAP;
      ST_PMAP:      state_nxt = ST_PATH_RD;
      ST_PATH_RD:   state_nxt = ST_PATH_WR;
      ST_PATH_WR:   state_nxt = stat.path_last ? ST_SRCH_RD : ST_PATH_RD;
      ST_SRCH_RD:   state_nxt = ST_SRCH_CHK;
      ST_SRCH_CHK:  state_nxt = (stat.hit || stat.scan_last) ? ST_EVICT_RD : ST_SRCH_RD;
      ST_EVICT_RD:  state_nxt = ST_EVICT_CHK;
      ST_EVICT_CHK: state_nxt = stat.scan_last ? ST_DONE : ST_EVICT_RD;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    op        = OP_NONE;
    case (state_r)
      ST_CLEAR: op = OP_CLEAR;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) op = OP_ACCEPT;
      end
      ST_PMAP:      op = OP_PMAP;
      ST_PATH_RD:   op = OP_PATH_RD;
      ST_PATH_WR:   op = OP_PATH_WR;
      ST_SRCH_RD:   op = OP_SRCH_RD;
      ST_SRCH_CHK:  op = OP_SRCH_CHK;
      ST_EVICT_RD:  op = OP_EVICT_RD;
      ST_EVICT_CHK: op = OP_EVICT_CHK;
      ST_DONE:      out_valid = 1'b1;
      default:      op = OP_NONE;
    endcase
  end

  `PORAM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `PORAM_ASSERT_NEXT(a_word_single, out_valid, !out_valid)
  `PORAM_ASSERT(a_word_not_idle, !(out_valid && !busy))
  `PORAM_ASSERT_NEXT(a_word_then_idle, out_valid, !busy)

endmodule

// File: hw/rtl/path_oram_access_controller.sv
`timescale 1ns / 1ps
// Tree-path oblivious access unit: after reset it runs a clearing pass over all 8188
// tree slots (one tree slot a cycle, position map cleared alongside) with busy high.
// An access is taken when start is high and busy low, and its word appears on the
// out_ ports for one cycle with out_valid; the receiver cannot stall, so it must take it
// then. Each access moves the valid blocks of every path slot (44 slots) into the stash,
// searches the stash entries for the id until a hit, then visits every stash entry for
// eviction, with busy low again the cycle after out_valid.
module path_oram_access_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  poram_pkg::in_t  in_item,
  output logic            out_valid,
  output poram_pkg::out_t out_item
);
  import poram_pkg::*;

  dp_op_t   op;
  dp_stat_t stat;

  poram_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .stat      (stat),
    .op        (op)
  );

  poram_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .op       (op),
    .in_item  (in_item),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule
